>>> sv/stereo_mix_accumulator_macros.svh
// Assertion macros used by the back part of the stereo mix accumulator RTL.
// Depends on nothing; the checks are left out when SYNTH is defined.
`ifndef STEREO_MIX_ACCUMULATOR_MACROS_SVH
`define STEREO_MIX_ACCUMULATOR_MACROS_SVH

`ifndef SYNTH
`define SMA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SMA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define SMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> sv/sma_pkg.sv
// Types, constants and saturation helpers for the stereo mix accumulator.
// Depends on nothing; the design files use it by scoped names, the testbench imports it.
package sma_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 8;
    localparam int SUM_W       = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] U8_CENTRE = 8'd128;

    localparam logic signed [SUM_W:0] SUM_MAX = 25'sd8388607;
    localparam logic signed [SUM_W:0] SUM_MIN = -25'sd8388608;
    localparam logic signed [SUM_W-1:0] OUT_MAX = 24'sd32767;
    localparam logic signed [SUM_W-1:0] OUT_MIN = -24'sd32768;

    typedef enum logic [1:0] {
        FMT_U8_MONO    = 2'd0,
        FMT_S16_MONO   = 2'd1,
        FMT_S16_STEREO = 2'd2
    } fmt_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw_left;
        logic [SAMPLE_W-1:0] raw_right;
        logic [1:0]          sample_format;
        logic [GAIN_W-1:0]   gain_left;
        logic [GAIN_W-1:0]   gain_right;
        logic                present;
        logic                frame_end;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_left;
        logic signed [SAMPLE_W-1:0] mixed_right;
    } mix_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] scaled_left;
        logic signed [SAMPLE_W-1:0] scaled_right;
        logic                       frame_end;
    } term_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]    acc,
        input logic signed [SAMPLE_W-1:0] add
    );
        logic signed [SUM_W:0] total;
        total = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - SAMPLE_W){add[SAMPLE_W-1]}}, add};
        if (total > SUM_MAX)
        begin
            return SUM_MAX[SUM_W-1:0];
        end
        else if (total < SUM_MIN)
        begin
            return SUM_MIN[SUM_W-1:0];
        end
        return total[SUM_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clamp_out(
        input logic signed [SUM_W-1:0] value
    );
        if (value > OUT_MAX)
        begin
            return OUT_MAX[SAMPLE_W-1:0];
        end
        else if (value < OUT_MIN)
        begin
            return OUT_MIN[SAMPLE_W-1:0];
        end
        return value[SAMPLE_W-1:0];
    endfunction

endpackage

>>> sv/sma_stream_if.sv
// Valid/ready stream channel carrying one item of a chosen payload type.
// Depends on nothing; payload types come from sma_pkg at instantiation.
interface sma_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/sma_front.sv
// Front part: decodes the sample format and applies both gains per item.
// Depends on sma_pkg and sma_stream_if.
module sma_front (
    sma_stream_if.sink   samples,
    sma_stream_if.source terms
);

    localparam int SW = sma_pkg::SAMPLE_W;
    localparam int GW = sma_pkg::GAIN_W;

    sma_pkg::sample_t           item;
    logic signed [SW-1:0]       sample_left;
    logic signed [SW-1:0]       sample_right;
    logic signed [SW+GW:0]      prod_left;
    logic signed [SW+GW:0]      prod_right;
    sma_pkg::term_t             term;

    assign item = samples.data;

    always_comb
    begin
        unique case (sma_pkg::fmt_t'(item.sample_format))
            sma_pkg::FMT_U8_MONO:
            begin
                sample_left  = {item.raw_left[7:0] - sma_pkg::U8_CENTRE, 8'h00};
                sample_right = sample_left;
            end
            sma_pkg::FMT_S16_MONO:
            begin
                sample_left  = item.raw_left;
                sample_right = item.raw_left;
            end
            default:
            begin
                sample_left  = item.raw_left;
                sample_right = item.raw_right;
            end
        endcase
    end

    assign prod_left  = sample_left * $signed({1'b0, item.gain_left});
    assign prod_right = sample_right * $signed({1'b0, item.gain_right});

    always_comb
    begin
        term.frame_end = item.frame_end;
        if (item.present)
        begin
            term.scaled_left  = prod_left[SW+GW-1:GW];
            term.scaled_right = prod_right[SW+GW-1:GW];
        end
        else
        begin
            term.scaled_left  = '0;
            term.scaled_right = '0;
        end
    end

    assign terms.valid   = samples.valid;
    assign terms.data    = term;
    assign samples.ready = terms.ready;

endmodule

>>> sv/sma_fifo.sv
// Short queue of scaled terms between the front and the back parts.
// Depends on sma_pkg and sma_stream_if.
module sma_fifo #(
    parameter int DEPTH = sma_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    sma_stream_if.sink   wr,
    sma_stream_if.source rd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sma_pkg::term_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr.ready = (count_reg != FULL_CNT);
    assign rd.valid = (count_reg != '0);
    assign rd.data  = mem_reg[rd_ptr_reg];
    assign push     = wr.valid && wr.ready;
    assign pop      = rd.valid && rd.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr.data;
        end
    end

endmodule

>>> sv/sma_back.sv
// Back part: saturating accumulation of terms and the frame result register.
// Depends on sma_pkg, sma_stream_if and the assertion macro header.
`include "stereo_mix_accumulator_macros.svh"

module sma_back (
    input  logic         clk,
    input  logic         rst_n,
    sma_stream_if.sink   terms,
    sma_stream_if.source mix
);

    localparam int SUM_W = sma_pkg::SUM_W;

    sma_pkg::term_t          head;
    logic signed [SUM_W-1:0] sum_left_reg;
    logic signed [SUM_W-1:0] sum_left_next;
    logic signed [SUM_W-1:0] sum_right_reg;
    logic signed [SUM_W-1:0] sum_right_next;
    logic signed [SUM_W-1:0] add_left;
    logic signed [SUM_W-1:0] add_right;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    sma_pkg::mix_t           out_data_reg;
    sma_pkg::mix_t           out_data_next;
    logic                    pop;

    assign head        = terms.data;
    assign terms.ready = !head.frame_end || !out_valid_reg || mix.ready;
    assign pop         = terms.valid && terms.ready;
    assign add_left    = sma_pkg::sat_add(sum_left_reg, head.scaled_left);
    assign add_right   = sma_pkg::sat_add(sum_right_reg, head.scaled_right);

    always_comb
    begin
        sum_left_next  = sum_left_reg;
        sum_right_next = sum_right_reg;
        out_valid_next = out_valid_reg && !mix.ready;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            if (head.frame_end)
            begin
                sum_left_next             = '0;
                sum_right_next            = '0;
                out_valid_next            = 1'b1;
                out_data_next.mixed_left  = sma_pkg::clamp_out(add_left);
                out_data_next.mixed_right = sma_pkg::clamp_out(add_right);
            end
            else
            begin
                sum_left_next  = add_left;
                sum_right_next = add_right;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_left_reg  <= '0;
            sum_right_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_left_reg  <= sum_left_next;
            sum_right_reg <= sum_right_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign mix.valid = out_valid_reg;
    assign mix.data  = out_data_reg;

    `SMA_ASSERT_NEXT(a_sums_cleared, clk, rst_n, pop && head.frame_end, (sum_left_reg == '0) && (sum_right_reg == '0), "Sums not cleared after frame end.")
    `SMA_ASSERT_NEXT(a_result_loaded, clk, rst_n, pop && head.frame_end, out_valid_reg, "Frame result not loaded.")
    `SMA_ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, terms.valid && head.frame_end && out_valid_reg && !mix.ready, !terms.ready, "Frame end taken while result is stalled.")

endmodule

>>> sv/stereo_mix_accumulator.sv
// Top level of the stereo mix accumulator: front, queue and back part.
// Depends on sma_pkg, sma_stream_if, sma_front, sma_fifo and sma_back.
//
// The block takes one channel contribution per clock cycle while its queue
// has room and returns one saturated stereo result for each item marked
// frame end, through the queue and the back part's result register. The rate
// is set by the two gain multipliers in the front part and the 24-bit
// saturating accumulator in the back part, each handling one item per cycle
// unless held by back-pressure. A queue of QUEUE_DEPTH scaled items decouples
// the two, so input keeps flowing while a finished frame result waits to be
// taken; input stalls only once that queue is full behind a stalled result.
module stereo_mix_accumulator #(
    parameter int QUEUE_DEPTH = sma_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    sma_stream_if.sink   samples,
    sma_stream_if.source mix
);

    sma_stream_if #(.payload_t(sma_pkg::term_t)) front_terms ();
    sma_stream_if #(.payload_t(sma_pkg::term_t)) queued_terms ();

    sma_front u_front (
        .samples (samples),
        .terms   (front_terms)
    );

    sma_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (front_terms),
        .rd    (queued_terms)
    );

    sma_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .terms (queued_terms),
        .mix   (mix)
    );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stereo_mix_accumulator: directed, long-frame and random items.
// Depends on sma_pkg, sma_stream_if and the stereo_mix_accumulator RTL.
module tb;
    import sma_pkg::*;

    localparam int MAX_CHANNELS = 8;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 450;
    localparam logic [1:0] FMT_SPARE = 2'd3;

    logic clk;
    logic rst_n;

    sma_stream_if #(.payload_t(sample_t)) samples ();
    sma_stream_if #(.payload_t(mix_t)) mix ();

    stereo_mix_accumulator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .mix     (mix)
    );

    logic signed [SUM_W-1:0] mix_sum_left;
    logic signed [SUM_W-1:0] mix_sum_right;
    mix_t                    pending_mixes[$];
    mix_t                    want_mix;
    bit                      no_idle;
    int                      errors;
    int                      items_sent;
    int                      mixes_checked;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string line);
        $display("%0t ns: %s", $time, line);
        errors++;
    endtask

    function automatic sample_t pack_item(
        input logic [15:0] raw_l,
        input logic [15:0] raw_r,
        input logic [1:0]  fmt,
        input logic [7:0]  g_l,
        input logic [7:0]  g_r,
        input logic        here,
        input logic        last
    );
        sample_t s;
        s.raw_left      = raw_l;
        s.raw_right     = raw_r;
        s.sample_format = fmt;
        s.gain_left     = g_l;
        s.gain_right    = g_r;
        s.present       = here;
        s.frame_end     = last;
        return s;
    endfunction

    function automatic int apply_gain(input int smp, input logic [7:0] g);
        int prod;
        prod = smp * int'(g);
        return prod >>> 8;
    endfunction

    function automatic logic signed [SUM_W-1:0] add_limited(
        input logic signed [SUM_W-1:0] acc,
        input int                      term
    );
        int total;
        total = int'(acc) + term;
        if (total > int'(SUM_MAX))
        begin
            total = int'(SUM_MAX);
        end
        if (total < int'(SUM_MIN))
        begin
            total = int'(SUM_MIN);
        end
        return total[SUM_W-1:0];
    endfunction

    function automatic logic signed [15:0] clip_to_out(input logic signed [SUM_W-1:0] v);
        int x;
        x = int'(v);
        if (x > int'(OUT_MAX))
        begin
            x = int'(OUT_MAX);
        end
        if (x < int'(OUT_MIN))
        begin
            x = int'(OUT_MIN);
        end
        return x[15:0];
    endfunction

    function automatic void predict_mix(input sample_t s, output bit emits, output mix_t res);
        int smp_l;
        int smp_r;
        if (s.present)
        begin
            case (s.sample_format)
                FMT_U8_MONO:
                begin
                    smp_l = (int'(s.raw_left[7:0]) - int'(U8_CENTRE)) * 256;
                    smp_r = smp_l;
                end
                FMT_S16_MONO:
                begin
                    smp_l = int'($signed(s.raw_left));
                    smp_r = smp_l;
                end
                default:
                begin
                    smp_l = int'($signed(s.raw_left));
                    smp_r = int'($signed(s.raw_right));
                end
            endcase
            mix_sum_left  = add_limited(mix_sum_left, apply_gain(smp_l, s.gain_left));
            mix_sum_right = add_limited(mix_sum_right, apply_gain(smp_r, s.gain_right));
        end
        emits = s.frame_end;
        res   = '0;
        if (s.frame_end)
        begin
            res.mixed_left  = clip_to_out(mix_sum_left);
            res.mixed_right = clip_to_out(mix_sum_right);
            mix_sum_left    = '0;
            mix_sum_right   = '0;
        end
    endfunction

    task automatic send_item(input sample_t s);
        int   gap;
        bit   emits;
        mix_t res;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            samples.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples.data  <= s;
        samples.valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!samples.ready);
        predict_mix(s, emits, res);
        if (emits)
        begin
            pending_mixes.push_back(res);
        end
        items_sent++;
    endtask

    task automatic wait_mixes_done();
        samples.valid <= 1'b0;
        while (pending_mixes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int stall;
        mix.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                mix.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            mix.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(mix.valid && mix.ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && mix.valid && mix.ready)
        begin
            if (pending_mixes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected mix left %0d right %0d",
                    mix.data.mixed_left, mix.data.mixed_right));
            end
            else
            begin
                want_mix = pending_mixes.pop_front();
                mixes_checked++;
                if (mix.data.mixed_left !== want_mix.mixed_left)
                begin
                    report_mismatch($sformatf("mixed_left expected %0d got %0d",
                        want_mix.mixed_left, mix.data.mixed_left));
                end
                if (mix.data.mixed_right !== want_mix.mixed_right)
                begin
                    report_mismatch($sformatf("mixed_right expected %0d got %0d",
                        want_mix.mixed_right, mix.data.mixed_right));
                end
            end
        end
    end

    task automatic test_directed_cases();
        send_item(pack_item(16'h5A5A, 16'hA5A5, FMT_S16_STEREO, 8'd255, 8'd255, 1'b0, 1'b1));
        send_item(pack_item(16'h0000, 16'h0000, FMT_U8_MONO, 8'd255, 8'd255, 1'b1, 1'b1));
        send_item(pack_item(16'hABFF, 16'hFFFF, FMT_U8_MONO, 8'd255, 8'd1, 1'b1, 1'b1));
        send_item(pack_item(16'h0080, 16'h1234, FMT_U8_MONO, 8'd255, 8'd255, 1'b1, 1'b1));
        send_item(pack_item(16'h8000, 16'h7FFF, FMT_S16_MONO, 8'd255, 8'd0, 1'b1, 1'b1));
        send_item(pack_item(16'h7FFF, 16'h8000, FMT_S16_MONO, 8'd128, 8'd255, 1'b1, 1'b1));
        send_item(pack_item(16'h7FFF, 16'h8000, FMT_S16_STEREO, 8'd255, 8'd255, 1'b1, 1'b0));
        send_item(pack_item(16'hFFFF, 16'hFFFF, FMT_SPARE, 8'd255, 8'd255, 1'b0, 1'b0));
        send_item(pack_item(16'hFFFF, 16'h0001, FMT_S16_STEREO, 8'd255, 8'd255, 1'b1, 1'b1));
        send_item(pack_item(16'h1234, 16'hEDCB, FMT_SPARE, 8'd200, 8'd100, 1'b1, 1'b1));
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            send_item(pack_item(16'h7FFF, 16'h8000, FMT_S16_STEREO, 8'd255, 8'd255, 1'b1,
                i == MAX_CHANNELS - 1));
        end
        send_item(pack_item(16'hFFFF, 16'hFFFF, FMT_S16_MONO, 8'd1, 8'd1, 1'b1, 1'b1));
    endtask

    task automatic test_accumulator_limits();
        for (int i = 0; i < 270; i++)
        begin
            send_item(pack_item(16'h7FFF, 16'h8000, FMT_S16_STEREO, 8'd255, 8'd255, 1'b1, 1'b0));
        end
        for (int i = 0; i < 257; i++)
        begin
            send_item(pack_item(16'h8000, 16'h7FFF, FMT_S16_STEREO, 8'd255, 8'd255, 1'b1, 1'b0));
        end
        send_item(pack_item(16'h0000, 16'h0000, FMT_U8_MONO, 8'd0, 8'd0, 1'b0, 1'b1));
    endtask

    function automatic logic [7:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_random_frames();
        int      start;
        int      frame_len;
        int      frame_no;
        bit      broken;
        bit      paused;
        sample_t s;
        start    = items_sent;
        frame_no = 0;
        paused   = 1'b0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            no_idle   = (frame_no >= 40 && frame_no < 60);
            broken    = ($urandom_range(0, 9) == 0);
            frame_len = $urandom_range(1, MAX_CHANNELS);
            for (int i = 0; i < frame_len; i++)
            begin
                s = pack_item(16'($urandom), 16'($urandom), 2'($urandom_range(0, 3)),
                    pick_gain(), pick_gain(), $urandom_range(0, 9) != 0,
                    broken ? 1'($urandom) : (i == frame_len - 1));
                send_item(s);
            end
            frame_no++;
            if (!paused && items_sent - start >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                wait_mixes_done();
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        samples.valid <= 1'b0;
        samples.data  <= '0;
        mix_sum_left  = '0;
        mix_sum_right = '0;
        no_idle       = 1'b0;
        errors        = 0;
        items_sent    = 0;
        mixes_checked = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        wait_mixes_done();
        test_accumulator_limits();
        wait_mixes_done();
        test_random_frames();
        wait_mixes_done();

        $display("Sent %0d items covering every format, empty and absent frame ends,", items_sent);
        $display("output clamping and accumulator limits; %0d mixes checked.", mixes_checked);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
